// ===== rtl/assert_macros.svh =====
// shared assertion macros, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/vac_pkg.sv =====
package vac_pkg;

  localparam int MaxLag       = 64;
  localparam int MaxParticles = 256;
  localparam int VelW         = 24;

  localparam int LagW    = $clog2(MaxLag);
  localparam int PosW    = $clog2(MaxParticles);
  localparam int HistAw  = LagW + PosW;
  localparam int HistW   = 3 * VelW;
  localparam int HistDepth = MaxLag * MaxParticles;
  localparam int ProdW   = 2 * VelW;
  localparam int DotW    = ProdW + 2;
  localparam int SumW    = 64;
  localparam int CntW    = 16;
  localparam int PcW     = 9;
  localparam int FrameW  = 16;
  localparam int LagSelW = 6;
  localparam int DivW    = PcW + CntW;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 1;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgParticleCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgFirstOrigin   = 1'd1;

  // operation codes
  localparam logic OpSample = 1'b0;
  localparam logic OpRead   = 1'b1;

  // one lag entering the multiply-accumulate pipeline
  typedef struct packed {
    logic            act;
    logic [LagW-1:0] lag;
    logic            ok;
    logic            eof;
    logic            vld;
  } mac_tag_t;

  // write-back of one lag's sum and origin count
  typedef struct packed {
    logic                   we;
    logic [LagW-1:0]        lag;
    logic signed [SumW-1:0] sum;
    logic [CntW-1:0]        cnt;
  } mac_wr_t;

endpackage

// ===== rtl/vac_ram.sv =====
module vac_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vac_div.sv =====
`include "assert_macros.svh"

module vac_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [vac_pkg::SumW-1:0] dividend_i,
  input  logic [vac_pkg::DivW-1:0]        divisor_i,
  output logic signed [vac_pkg::SumW-1:0] quotient_o,
  output logic                            done_o,
  output logic                            busy_o
);

  localparam int StepW = $clog2(vac_pkg::SumW);
  localparam logic [StepW-1:0] StepLast = StepW'(vac_pkg::SumW - 1);

  logic                        busy_q, done_q, neg_q;
  logic [StepW-1:0]            step_q;
  logic [vac_pkg::SumW-1:0]    quo_q, mag;
  logic [vac_pkg::DivW-1:0]    rem_q, dsr_q;
  logic [vac_pkg::DivW:0]      rem_sh, diff;
  logic                        ge;

  assign mag    = dividend_i[vac_pkg::SumW-1] ? vac_pkg::SumW'(-dividend_i)
                                              : vac_pkg::SumW'(dividend_i);
  assign rem_sh = {rem_q, quo_q[vac_pkg::SumW-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign ge     = !diff[vac_pkg::DivW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[vac_pkg::SumW-1];
      quo_q <= mag;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[vac_pkg::DivW-1:0] : rem_sh[vac_pkg::DivW-1:0];
      quo_q <= {quo_q[vac_pkg::SumW-2:0], ge};
    end
  end

  assign quotient_o = neg_q ? vac_pkg::SumW'(-quo_q) : vac_pkg::SumW'(quo_q);
  assign done_o     = done_q;
  assign busy_o     = busy_q;

  `ASSERT_NEVER(a_start_while_busy, start_i && busy_q, "divider restarted while busy")
  `ASSERT_CLK(a_done_after_busy, done_q |-> $past(busy_q), "done without a running division")

endmodule

// ===== rtl/vac_mac.sv =====
module vac_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vac_pkg::mac_tag_t                issue_i,
  input  logic signed [vac_pkg::VelW-1:0]  vel_x_i,
  input  logic signed [vac_pkg::VelW-1:0]  vel_y_i,
  input  logic signed [vac_pkg::VelW-1:0]  vel_z_i,
  input  logic [vac_pkg::HistW-1:0]        hist_rdata_i,
  input  logic signed [vac_pkg::SumW-1:0]  sum_rdata_i,
  input  logic [vac_pkg::CntW-1:0]         cnt_rdata_i,
  output vac_pkg::mac_wr_t                 wr_o,
  output logic                             busy_o
);

  localparam logic signed [vac_pkg::SumW-1:0] SumMax = {1'b0, {(vac_pkg::SumW-1){1'b1}}};
  localparam logic signed [vac_pkg::SumW-1:0] SumMin = {1'b1, {(vac_pkg::SumW-1){1'b0}}};

  vac_pkg::mac_tag_t t1_q, t2_q, t3_q;

  logic signed [vac_pkg::VelW-1:0]  hx, hy, hz;
  logic signed [vac_pkg::ProdW-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic signed [vac_pkg::SumW-1:0]  sum1, sum2_q, sum3_q, sum_new;
  logic [vac_pkg::CntW-1:0]         cnt1, cnt2_q, cnt3_q, cnt_new;
  logic signed [vac_pkg::DotW-1:0]  dot_d, dot_q;
  logic signed [vac_pkg::SumW:0]    sum_ext, dot_ext, acc;

  // stage 1: history and sum/count data arrive from the memories
  assign hx   = signed'(hist_rdata_i[vac_pkg::HistW-1 -: vac_pkg::VelW]);
  assign hy   = signed'(hist_rdata_i[2*vac_pkg::VelW-1 -: vac_pkg::VelW]);
  assign hz   = signed'(hist_rdata_i[vac_pkg::VelW-1:0]);
  assign px_d = vel_x_i * hx;
  assign py_d = vel_y_i * hy;
  assign pz_d = vel_z_i * hz;
  assign sum1 = t1_q.vld ? sum_rdata_i : '0;
  assign cnt1 = t1_q.vld ? cnt_rdata_i : '0;

  // stage 2: dot product, never overflows the widened sum
  assign dot_d = vac_pkg::DotW'(px_q) + vac_pkg::DotW'(py_q) + vac_pkg::DotW'(pz_q);

  // stage 3: saturating accumulate
  assign sum_ext = (vac_pkg::SumW+1)'(sum3_q);
  assign dot_ext = (vac_pkg::SumW+1)'(dot_q);
  assign acc     = sum_ext + dot_ext;

  always_comb begin
    if (acc[vac_pkg::SumW] != acc[vac_pkg::SumW-1]) begin
      sum_new = acc[vac_pkg::SumW] ? SumMin : SumMax;
    end else begin
      sum_new = acc[vac_pkg::SumW-1:0];
    end
    if (t3_q.eof && cnt3_q != vac_pkg::CntMax) begin
      cnt_new = cnt3_q + vac_pkg::CntW'(1);
    end else begin
      cnt_new = cnt3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else begin
      t1_q <= issue_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    sum2_q <= sum1;
    cnt2_q <= cnt1;
    dot_q  <= dot_d;
    sum3_q <= sum2_q;
    cnt3_q <= cnt2_q;
  end

  assign wr_o.we  = t3_q.act && t3_q.ok;
  assign wr_o.lag = t3_q.lag;
  assign wr_o.sum = sum_new;
  assign wr_o.cnt = cnt_new;
  assign busy_o   = t1_q.act || t2_q.act || t3_q.act;

endmodule

// ===== rtl/velocity_autocorrelation_core.sv =====
// Streaming velocity autocorrelation. A sample transfer (operation 0) carries one particle's
// velocity; particles come in order and a frame closes after particle_count samples. The
// sample is stored in a history of the last 64 frames and, for every lag whose origin frame
// exists and is not before first_origin_frame, its dot product with the same particle's
// velocity at that origin is added to a saturating 64-bit lag sum; a closing sample also
// bumps those lags' origin counts. A read transfer (operation 1) returns one lag's sum divided
// by particle_count times its origin count (the sum itself when the count is zero). One item
// is in work at a time. A sample issues its lags in order, one multiply-accumulate pass per
// lag through a single pipelined unit fed by the history memory's one read port, then
// drains the pipeline and returns to the idle state that takes the next transfer. A read
// with a nonzero count runs the divider, which retires one quotient bit per cycle; a read
// with a zero count skips it. A result that waits for out_ready_i holds the input off for
// as long as it waits. The history memory needs no clearing pass; lag sums and counts read
// as zero until first written, so the block is ready right after reset.
`include "assert_macros.svh"

module velocity_autocorrelation_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vac_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [vac_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic signed [vac_pkg::VelW-1:0]    vel_x_i,
  input  logic signed [vac_pkg::VelW-1:0]    vel_y_i,
  input  logic signed [vac_pkg::VelW-1:0]    vel_z_i,
  input  logic [vac_pkg::LagSelW-1:0]        lag_select_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [vac_pkg::LagSelW-1:0]        lag_echo_o,
  output logic signed [vac_pkg::SumW-1:0]    mean_correlation_o,
  output logic [vac_pkg::CntW-1:0]           origin_total_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_DRAIN = 6'b000100,
    S_RD    = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  localparam logic [1:0] DrainLast = 2'd2;
  localparam logic [vac_pkg::LagW-1:0] LagLast = vac_pkg::LagW'(vac_pkg::MaxLag - 1);

  state_e state_q, state_d;

  logic [vac_pkg::PcW-1:0]    pc_q, n_eff;
  logic [vac_pkg::FrameW-1:0] fof_q, frame_q, frame_lag;
  logic [vac_pkg::PosW-1:0]   pos_q;
  logic [vac_pkg::LagW-1:0]   lag_q, lag_raddr;
  logic [1:0]                 drain_q;
  logic                       eof_q, eof_d;
  logic [vac_pkg::MaxLag-1:0] ent_vld_q;
  logic                       lag_ok;

  logic accept, sample_acc, read_acc;

  logic signed [vac_pkg::VelW-1:0] vx_q, vy_q, vz_q;

  logic [vac_pkg::HistAw-1:0] hist_waddr, hist_raddr;
  logic [vac_pkg::HistW-1:0]  hist_rdata;
  logic signed [vac_pkg::SumW-1:0] sum_rdata;
  logic [vac_pkg::CntW-1:0]   cnt_rdata;

  vac_pkg::mac_tag_t issue;
  vac_pkg::mac_wr_t  wr;
  logic              mac_busy;

  logic [vac_pkg::LagSelW-1:0]     rd_sel_q;
  logic                            rd_vld_q, rd_in_range;
  logic signed [vac_pkg::SumW-1:0] rd_sum;
  logic [vac_pkg::CntW-1:0]        rd_cnt;
  logic [vac_pkg::DivW-1:0]        divisor;
  logic                            div_start, div_done, div_busy;
  logic signed [vac_pkg::SumW-1:0] div_quotient;

  logic signed [vac_pkg::SumW-1:0] res_mean_q;
  logic [vac_pkg::CntW-1:0]        res_cnt_q;

  logic                            out_valid_q, out_load;
  logic [vac_pkg::LagSelW-1:0]     out_lag_q;
  logic signed [vac_pkg::SumW-1:0] out_mean_q;
  logic [vac_pkg::CntW-1:0]        out_cnt_q;

  // particle count as used: zero means one, above MaxParticles clamps to MaxParticles
  always_comb begin
    if (pc_q == '0) begin
      n_eff = vac_pkg::PcW'(1);
    end else if (pc_q > vac_pkg::PcW'(vac_pkg::MaxParticles)) begin
      n_eff = vac_pkg::PcW'(vac_pkg::MaxParticles);
    end else begin
      n_eff = pc_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign sample_acc = accept && (operation_i == vac_pkg::OpSample);
  assign read_acc   = accept && (operation_i == vac_pkg::OpRead);

  assign eof_d = (vac_pkg::PcW'(pos_q) + vac_pkg::PcW'(1)) >= n_eff;

  // origin frame of the lag being issued
  assign frame_lag = frame_q - vac_pkg::FrameW'(lag_q);
  assign lag_ok    = (frame_q >= vac_pkg::FrameW'(lag_q)) && (frame_lag >= fof_q);

  assign hist_waddr = {frame_q[vac_pkg::LagW-1:0], pos_q};
  assign hist_raddr = {frame_lag[vac_pkg::LagW-1:0], pos_q};
  assign lag_raddr  = (state_q == S_IDLE) ? vac_pkg::LagW'(lag_select_i) : lag_q;

  always_comb begin
    issue = '0;
    if (state_q == S_MAC) begin
      issue.act = 1'b1;
      issue.lag = lag_q;
      issue.ok  = lag_ok;
      issue.eof = eof_q;
      issue.vld = ent_vld_q[lag_q];
    end
  end

  vac_ram #(
    .Width (vac_pkg::HistW),
    .Depth (vac_pkg::HistDepth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (sample_acc),
    .waddr_i (hist_waddr),
    .wdata_i ({vel_x_i, vel_y_i, vel_z_i}),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  vac_ram #(
    .Width (vac_pkg::SumW),
    .Depth (vac_pkg::MaxLag)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.lag),
    .wdata_i (wr.sum),
    .raddr_i (lag_raddr),
    .rdata_o (sum_rdata)
  );

  vac_ram #(
    .Width (vac_pkg::CntW),
    .Depth (vac_pkg::MaxLag)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.lag),
    .wdata_i (wr.cnt),
    .raddr_i (lag_raddr),
    .rdata_o (cnt_rdata)
  );

  vac_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .vel_x_i      (vx_q),
    .vel_y_i      (vy_q),
    .vel_z_i      (vz_q),
    .hist_rdata_i (hist_rdata),
    .sum_rdata_i  (sum_rdata),
    .cnt_rdata_i  (cnt_rdata),
    .wr_o         (wr),
    .busy_o       (mac_busy)
  );

  // read path
  assign rd_sum      = rd_vld_q ? sum_rdata : '0;
  assign rd_cnt      = rd_vld_q ? cnt_rdata : '0;
  assign rd_in_range = 32'(rd_sel_q) < vac_pkg::MaxLag;
  assign div_start   = (state_q == S_RD) && rd_in_range && (rd_cnt != '0);
  assign divisor     = vac_pkg::DivW'(n_eff) * vac_pkg::DivW'(rd_cnt);

  vac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_sum),
    .divisor_i  (divisor),
    .quotient_o (div_quotient),
    .done_o     (div_done),
    .busy_o     (div_busy)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (sample_acc) begin
          state_d = S_MAC;
        end else if (read_acc) begin
          state_d = S_RD;
        end
      end
      S_MAC: begin
        if (lag_q == LagLast) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_q == DrainLast) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = div_start ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= vac_pkg::PcW'(1);
      fof_q       <= '0;
      frame_q     <= '0;
      pos_q       <= '0;
      lag_q       <= '0;
      drain_q     <= '0;
      eof_q       <= 1'b0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          vac_pkg::CfgParticleCount: pc_q  <= cfg_wdata_i[vac_pkg::PcW-1:0];
          vac_pkg::CfgFirstOrigin:   fof_q <= cfg_wdata_i[vac_pkg::FrameW-1:0];
          default: ;
        endcase
      end

      if (sample_acc) begin
        lag_q <= '0;
        eof_q <= eof_d;
      end else if (state_q == S_MAC) begin
        lag_q   <= lag_q + vac_pkg::LagW'(1);
        drain_q <= '0;
      end else if (state_q == S_DRAIN) begin
        drain_q <= drain_q + 2'd1;
        // sample retired: advance particle and frame
        if (drain_q == DrainLast) begin
          if (eof_q) begin
            pos_q   <= '0;
            frame_q <= frame_q + vac_pkg::FrameW'(1);
          end else begin
            pos_q <= pos_q + vac_pkg::PosW'(1);
          end
        end
      end

      if (wr.we) begin
        ent_vld_q[wr.lag] <= 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
      vz_q <= vel_z_i;
    end
    if (read_acc) begin
      rd_sel_q <= lag_select_i;
      rd_vld_q <= ent_vld_q[vac_pkg::LagW'(lag_select_i)];
    end
    if (state_q == S_RD) begin
      res_mean_q <= rd_in_range ? rd_sum : '0;
      res_cnt_q  <= rd_in_range ? rd_cnt : '0;
    end else if (state_q == S_DIV && div_done) begin
      res_mean_q <= div_quotient;
    end
    if (out_load) begin
      out_lag_q  <= rd_sel_q;
      out_mean_q <= res_mean_q;
      out_cnt_q  <= res_cnt_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign lag_echo_o         = out_lag_q;
  assign mean_correlation_o = out_mean_q;
  assign origin_total_o     = out_cnt_q;

  `ASSERT_NEVER(a_wr_outside_sample, wr.we && !(state_q == S_MAC || state_q == S_DRAIN), "lag write-back outside a sample")
  `ASSERT_NEVER(a_idle_with_mac_busy, (state_q == S_IDLE) && mac_busy, "idle with the accumulate pipeline not drained")
  `ASSERT_NEVER(a_div_outside_read, div_busy && (state_q != S_DIV), "divider running outside a read")

endmodule
